// ===== hw/rtl/nss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types and codes of the note step sequencer.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int OP_W     = 3;
  localparam int PITCH_W  = 16;
  localparam int LEN_W    = 8;
  localparam int DRAW_W   = 8;
  localparam int EVENT_W  = 2;
  localparam int ORDER_W  = 2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register indexes (word address)
  localparam logic REG_STEP_ORDER = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_PUSH  = 3'd1,
    OP_POP   = 3'd2,
    OP_CLEAR = 3'd3,
    OP_START = 3'd4,
    OP_STOP  = 3'd5
  } op_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_ALL_OFF  = 2'd2
  } event_t;

  typedef enum logic [ORDER_W-1:0] {
    ORD_FORWARD  = 2'd0,
    ORD_BACKWARD = 2'd1,
    ORD_RANDOM   = 2'd2
  } order_t;

  typedef struct packed {
    logic                      has_pitch;
    logic signed [PITCH_W-1:0] pitch;
    logic [LEN_W-1:0]          length;
  } step_entry_t;

endpackage

// ===== hw/rtl/nss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_if
// Valid/ready channels of the note step sequencer: command items and events.
// ----------------------------------------------------------------------------
interface nss_item_if
  import nss_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic                      pitch_valid;
  logic signed [PITCH_W-1:0] step_pitch;
  logic [LEN_W-1:0]          step_length;
  logic signed [PITCH_W-1:0] start_offset;
  logic [DRAW_W-1:0]         random_draw;

  modport source (
    output valid, operation, pitch_valid, step_pitch, step_length, start_offset,
           random_draw,
    input  ready
  );
  modport sink (
    input  valid, operation, pitch_valid, step_pitch, step_length, start_offset,
           random_draw,
    output ready
  );
endinterface

interface nss_event_if
  import nss_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [EVENT_W-1:0]        event_res;
  logic signed [PITCH_W-1:0] note_pitch;
  logic                      last;

  modport source (
    output valid, event_res, note_pitch, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, note_pitch, last,
    output ready
  );
endinterface

// ===== hw/rtl/nss_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_cfg_regs
// APB register block: holds the step order register.
// ----------------------------------------------------------------------------
module nss_cfg_regs
  import nss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ORDER_W-1:0]    step_order
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_STEP_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_order <= ORD_FORWARD;
    end else if (wr_en) begin
      step_order <= pwdata[ORDER_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STEP_ORDER) begin
      prdata[ORDER_W-1:0] = step_order;
    end
  end

endmodule

// ===== hw/rtl/nss_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module nss_mod_unit #(
  parameter int DW = 8,
  parameter int CW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    dvd;
  logic [CW-1:0]    dsr;
  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;
  logic [CW-1:0]    rem_next;

  // remainder stays below divisor, so the shifted trial fits CW+1 bits
  assign trial     = {rem, dvd[DW-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign rem_next  = (trial >= {1'b0, dsr}) ? trial_sub[CW-1:0] : trial[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/note_step_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_step_sequencer
// Step sequencer core: step table, playback position and note events.
// ----------------------------------------------------------------------------
//  channel   dir  modport        carries
//  item      in   nss_item_if    tick/push/pop/clear/start/stop commands
//  result    out  nss_event_if   note on / note off / all notes off, last flag
//  apb       in   psel..pready   step_order register at byte address 0
//
//  Push, clear, start, other pops, a tick that only counts down and ignored
//  items are done while idle; stop and a tick that ends a step on an empty
//  table go straight to event output; a pop that removes the playing step
//  reads the step table before its events go out.
//  A tick that ends a step on a non-empty table works out the next position
//  in the bit-serial remainder unit over DW dividend bits (DW = 8 at the
//  default size), then does one registered read of the step table.
//  Reset is synchronous; the step table is not cleared, only step_count.
//  A stalled result holds in the output register; no new item is taken
//  until all events of the current one are loaded into it.
// ----------------------------------------------------------------------------
module note_step_sequencer
  import nss_pkg::*;
#(
  parameter int MAX_STEPS  = 16,
  parameter int PITCH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  nss_item_if.sink              item,
  nss_event_if.source           result
);

  localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int DW = (PW + 1 > DRAW_W) ? PW + 1 : DRAW_W;
  localparam logic signed [32:0] SAT_HI =
    33'((64'sd1 <<< (PITCH_BITS - 1)) - 64'sd1);
  localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_TDATA,
    S_PDATA,
    S_EMIT
  } state_t;

  state_t state;

  logic [ORDER_W-1:0]        step_order;
  step_entry_t               mem [MAX_STEPS];
  step_entry_t               rd_data;
  logic [PW-1:0]             rd_addr;
  logic                      mem_we;

  logic [CW-1:0]             step_count;
  logic [CW-1:0]             cnt_m1;
  logic [PW-1:0]             position;
  logic                      position_valid;
  logic [LEN_W-1:0]          beats_left;
  logic                      playing;
  logic signed [PITCH_W-1:0] active_offset;
  logic                      sound_valid;
  logic signed [PITCH_W-1:0] sound_pitch;

  logic                      pend_off;
  logic                      pend_on;
  logic                      pend_all;
  logic signed [PITCH_W-1:0] off_pitch;

  logic                      out_valid;
  logic [EVENT_W-1:0]        out_event;
  logic signed [PITCH_W-1:0] out_pitch;
  logic                      out_last;
  logic                      slot_free;
  logic                      out_load;

  logic                      accept;
  logic                      mod_start;
  logic                      mod_done;
  logic [CW-1:0]             mod_rem;
  logic [DW-1:0]             dividend;
  logic [DW-1:0]             pos_ext;
  logic [DW-1:0]             cnt_ext;
  logic                      pop_hits;

  logic signed [16:0]        pitch_sum;
  logic signed [32:0]        sum_w;
  logic signed [PITCH_W-1:0] sat_pitch;

  nss_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .step_order (step_order)
  );

  nss_mod_unit #(
    .DW (DW),
    .CW (CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (dividend),
    .divisor  (step_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign accept    = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign cnt_m1    = step_count - 1'b1;
  assign pos_ext   = DW'(position);
  assign cnt_ext   = DW'(step_count);
  assign pop_hits  = playing && position_valid && (CW'(position) == cnt_m1);

  // a tick that ends the step and has a table to move through
  assign mod_start = accept && (item.operation == OP_TICK) && playing &&
                     (beats_left <= LEN_W'(1)) && (step_count != '0);

  always_comb begin
    if (step_order == ORD_RANDOM) begin
      dividend = DW'(item.random_draw);
    end else if (step_order == ORD_BACKWARD) begin
      dividend = position_valid ? pos_ext + cnt_ext - DW'(1) : cnt_ext - DW'(1);
    end else begin
      dividend = position_valid ? pos_ext + DW'(1) : '0;
    end
  end

  // step table
  assign mem_we  = accept && (item.operation == OP_PUSH) &&
                   (step_count < CW'(MAX_STEPS));
  assign rd_addr = (state == S_MOD) ? mod_rem[PW-1:0] : cnt_m1[PW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[step_count[PW-1:0]] <= '{has_pitch: item.pitch_valid,
                                   pitch:     item.step_pitch,
                                   length:    item.step_length};
    end
    rd_data <= mem[rd_addr];
  end

  // note-on pitch: step pitch plus offset, clamped to PITCH_BITS
  assign pitch_sum = {rd_data.pitch[PITCH_W-1], rd_data.pitch} +
                     {active_offset[PITCH_W-1], active_offset};
  assign sum_w     = {{16{pitch_sum[16]}}, pitch_sum};

  always_comb begin
    if (sum_w > SAT_HI) begin
      sat_pitch = SAT_HI[PITCH_W-1:0];
    end else if (sum_w < SAT_LO) begin
      sat_pitch = SAT_LO[PITCH_W-1:0];
    end else begin
      sat_pitch = sum_w[PITCH_W-1:0];
    end
  end

  assign slot_free        = !out_valid || result.ready;
  assign out_load         = (state == S_EMIT) && slot_free &&
                            (pend_all || pend_off || pend_on);
  assign result.valid     = out_valid;
  assign result.event_res = out_event;
  assign result.note_pitch = out_pitch;
  assign result.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step_count     <= '0;
      position       <= '0;
      position_valid <= 1'b0;
      beats_left     <= '0;
      playing        <= 1'b0;
      active_offset  <= '0;
      sound_valid    <= 1'b0;
      sound_pitch    <= '0;
      pend_off       <= 1'b0;
      pend_on        <= 1'b0;
      pend_all       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && result.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.operation)
              OP_TICK: begin
                if (playing) begin
                  if (beats_left > LEN_W'(1)) begin
                    beats_left <= beats_left - 1'b1;
                  end else begin
                    beats_left <= '0;
                    if (sound_valid) begin
                      pend_off    <= 1'b1;
                      off_pitch   <= sound_pitch;
                      sound_valid <= 1'b0;
                    end
                    state <= (step_count != '0) ? S_MOD : S_EMIT;
                  end
                end
              end
              OP_PUSH: begin
                if (step_count < CW'(MAX_STEPS)) begin
                  step_count <= step_count + 1'b1;
                end
              end
              OP_POP: begin
                if (step_count != '0) begin
                  step_count <= cnt_m1;
                  if (pop_hits) begin
                    state <= S_PDATA;
                  end
                end
              end
              OP_CLEAR: begin
                step_count <= '0;
              end
              OP_START: begin
                if (!playing) begin
                  active_offset <= item.start_offset;
                  playing       <= 1'b1;
                end
              end
              OP_STOP: begin
                if (playing) begin
                  playing        <= 1'b0;
                  position       <= '0;
                  position_valid <= 1'b0;
                  beats_left     <= '0;
                  sound_valid    <= 1'b0;
                  sound_pitch    <= '0;
                  pend_all       <= 1'b1;
                  state          <= S_EMIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            position       <= mod_rem[PW-1:0];
            position_valid <= 1'b1;
            state          <= S_TDATA;
          end
        end
        S_TDATA: begin
          beats_left <= rd_data.length;
          if (rd_data.has_pitch) begin
            sound_valid <= 1'b1;
            sound_pitch <= sat_pitch;
            pend_on     <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_PDATA: begin
          if (rd_data.has_pitch && sound_valid) begin
            pend_off    <= 1'b1;
            off_pitch   <= sound_pitch;
            sound_valid <= 1'b0;
          end
          beats_left <= '0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            priority if (pend_all) begin
              pend_all  <= 1'b0;
              out_valid <= 1'b1;
              out_event <= EV_ALL_OFF;
              out_pitch <= '0;
              out_last  <= 1'b1;
            end else if (pend_off) begin
              pend_off  <= 1'b0;
              out_valid <= 1'b1;
              out_event <= EV_NOTE_OFF;
              out_pitch <= off_pitch;
              out_last  <= !pend_on;
            end else if (pend_on) begin
              pend_on   <= 1'b0;
              out_valid <= 1'b1;
              out_event <= EV_NOTE_ON;
              out_pitch <= sound_pitch;
              out_last  <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(pend_off || pend_on || pend_all))
    else $error("events pending while taking items");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    step_count <= CW'(MAX_STEPS))
    else $error("step count beyond table size");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder result outside of position update");

  a_all_off_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_event == EV_ALL_OFF)) |-> out_last)
    else $error("all notes off not marked last");

  a_position_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDATA) |-> (CW'(position) < step_count))
    else $error("new position outside the step table");

endmodule

// ===== bench/note_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_event_checker
// Watches the command and event channels of the note step sequencer. Keeps
// its own copy of the step table and playback state, works out the note
// events each accepted command beat must cause, and compares every event
// beat with the oldest one still due. Tracks step_order writes on the APB
// port. Hands the failure count and the number of events still due upward.
// ----------------------------------------------------------------------------
module note_event_checker
  import nss_pkg::*;
#(
  parameter int MAX_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  nss_item_if                   item,
  nss_event_if                  result,
  output int                    fail_count,
  output int                    pending
);

  localparam int PITCH_MAX    = (1 << (PITCH_W - 1)) - 1;
  localparam int PITCH_MIN    = -PITCH_MAX - 1;
  localparam int REPORT_LIMIT = 10;
  localparam logic [APB_ADDR_W-1:0] ORDER_ADDR = APB_ADDR_W'(4 * REG_STEP_ORDER);

  typedef struct packed {
    event_t                    ev;
    logic signed [PITCH_W-1:0] pitch;
    logic                      last;
  } note_event_t;

  order_t                    step_order;
  step_entry_t               steps [MAX_STEPS];
  int                        step_total;
  int                        cur_pos;
  int                        beats_left;
  logic                      pos_valid;
  logic                      playing;
  logic                      sounding;
  logic signed [PITCH_W-1:0] offset;
  logic signed [PITCH_W-1:0] sound_pitch;
  note_event_t               events_due [$];
  note_event_t               batch [$];
  int                        errors = 0;

  function automatic logic signed [PITCH_W-1:0] clamp_pitch(input int sum);
    if (sum > PITCH_MAX) return PITCH_W'(PITCH_MAX);
    if (sum < PITCH_MIN) return PITCH_W'(PITCH_MIN);
    return PITCH_W'(sum);
  endfunction

  task automatic emit(input event_t ev, input logic signed [PITCH_W-1:0] pitch);
    note_event_t e;
    e.ev    = ev;
    e.pitch = pitch;
    e.last  = 1'b0;
    batch.push_back(e);
  endtask

  task automatic advance_beat(input logic [DRAW_W-1:0] draw);
    if (!playing) return;
    if (beats_left > 1) begin
      beats_left--;
      return;
    end
    beats_left = 0;
    if (sounding) begin
      emit(EV_NOTE_OFF, sound_pitch);
      sounding = 1'b0;
    end
    if (step_total == 0) return;
    // position may sit past the table after pop or clear; modulo folds it back
    case (step_order)
      ORD_BACKWARD: begin
        cur_pos = pos_valid ? (cur_pos + step_total - 1) % step_total : step_total - 1;
      end
      ORD_RANDOM: begin
        cur_pos = int'(draw) % step_total;
      end
      default: begin
        cur_pos = pos_valid ? (cur_pos + 1) % step_total : 0;
      end
    endcase
    pos_valid  = 1'b1;
    beats_left = int'(steps[cur_pos].length);
    if (steps[cur_pos].has_pitch) begin
      sound_pitch = clamp_pitch(int'($signed(steps[cur_pos].pitch)) + int'(offset));
      sounding    = 1'b1;
      emit(EV_NOTE_ON, sound_pitch);
    end
  endtask

  task automatic predict_events(
    input logic [OP_W-1:0]           op,
    input logic                      pv,
    input logic signed [PITCH_W-1:0] pitch,
    input logic [LEN_W-1:0]          len,
    input logic signed [PITCH_W-1:0] ofs,
    input logic [DRAW_W-1:0]         draw
  );
    step_entry_t entry;
    batch.delete();
    case (op)
      OP_TICK: begin
        advance_beat(draw);
      end
      OP_PUSH: begin
        // full table drops the push
        if (step_total < MAX_STEPS) begin
          entry.has_pitch   = pv;
          entry.pitch       = pitch;
          entry.length      = len;
          steps[step_total] = entry;
          step_total++;
        end
      end
      OP_POP: begin
        if (step_total > 0) begin
          if (playing && pos_valid && cur_pos == step_total - 1) begin
            if (steps[cur_pos].has_pitch && sounding) begin
              emit(EV_NOTE_OFF, sound_pitch);
              sounding = 1'b0;
            end
            beats_left = 0;
          end
          step_total--;
        end
      end
      OP_CLEAR: begin
        step_total = 0;
      end
      OP_START: begin
        if (!playing) begin
          offset  = ofs;
          playing = 1'b1;
        end
      end
      OP_STOP: begin
        if (playing) begin
          playing     = 1'b0;
          cur_pos     = 0;
          pos_valid   = 1'b0;
          beats_left  = 0;
          sounding    = 1'b0;
          sound_pitch = '0;
          emit(EV_ALL_OFF, '0);
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) events_due.push_back(batch[i]);
  endtask

  task automatic report(input string what, input note_event_t want, input note_event_t got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t: %s: expected ev=%0d pitch=%h last=%b, got ev=%0d pitch=%h last=%b",
               $time, what, want.ev, want.pitch, want.last, got.ev, got.pitch, got.last);
    end
  endtask

  always @(posedge clk) begin
    note_event_t got;
    note_event_t want;
    if (rst) begin
      step_order  = ORD_FORWARD;
      step_total  = 0;
      cur_pos     = 0;
      pos_valid   = 1'b0;
      beats_left  = 0;
      playing     = 1'b0;
      offset      = '0;
      sounding    = 1'b0;
      sound_pitch = '0;
      events_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ORDER_ADDR) begin
        step_order = order_t'(pwdata[ORDER_W-1:0]);
      end
      if (item.valid && item.ready) begin
        predict_events(item.operation, item.pitch_valid, item.step_pitch, item.step_length,
                       item.start_offset, item.random_draw);
      end
      if (result.valid && result.ready) begin
        got.ev    = event_t'(result.event_res);
        got.pitch = result.note_pitch;
        got.last  = result.last;
        if (events_due.size() == 0) begin
          want = '0;
          report("event beat with nothing due", want, got);
        end else begin
          want = events_due.pop_front();
          if (got.ev !== want.ev || got.pitch !== want.pitch || got.last !== want.last) begin
            report("event mismatch", want, got);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= events_due.size();
  end

endmodule

// ===== bench/note_step_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_step_sequencer_tb
// Drives command beats into the note step sequencer and writes step_order
// over APB between phases. A short directed run walks the corner cases, then
// random playback sessions (push a table, start, tick, edit, stop) mixed with
// noise run under forward, backward and random order with varied idling on
// both channels. The checker beside the block predicts and compares events.
// ----------------------------------------------------------------------------
module note_step_sequencer_tb;
  import nss_pkg::*;

  localparam int STEP_SLOTS      = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int NUM_PHASES      = 6;
  localparam logic [OP_W-1:0]       OP_SPARE6  = 3'd6;
  localparam logic [OP_W-1:0]       OP_SPARE7  = 3'd7;
  localparam logic [APB_ADDR_W-1:0] ORDER_ADDR = APB_ADDR_W'(4 * REG_STEP_ORDER);

  localparam order_t PHASE_ORDER [NUM_PHASES] =
    '{ORD_FORWARD, ORD_BACKWARD, ORD_RANDOM, ORD_FORWARD, ORD_RANDOM, ORD_BACKWARD};
  localparam int PHASE_GAP   [NUM_PHASES] = '{0, 57, 0, 28, 28, 0};
  localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 57, 28, 28, 0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int gap_pct    = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cycles     = 0;
  int fail_count;
  int pending;

  nss_item_if  item_ch ();
  nss_event_if event_ch ();

  note_step_sequencer #(
    .MAX_STEPS (STEP_SLOTS),
    .PITCH_BITS(PITCH_W)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .item   (item_ch),
    .result (event_ch)
  );

  note_event_checker #(
    .MAX_STEPS(STEP_SLOTS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .item      (item_ch),
    .result    (event_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    event_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[note_step_sequencer] ERROR");
      $finish;
    end
  end

  // bias toward the saturation corners
  function automatic logic [PITCH_W-1:0] rnd_pitch();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      default: return PITCH_W'($urandom);
    endcase
  endfunction

  // mostly short steps so ticks keep expiring
  function automatic logic [LEN_W-1:0] rnd_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return LEN_W'($urandom_range(3));
    if (r < 97) return LEN_W'($urandom_range(15, 4));
    return LEN_W'($urandom_range(255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(
    input logic [OP_W-1:0]    op,
    input logic               pv,
    input logic [PITCH_W-1:0] pitch,
    input logic [LEN_W-1:0]   len,
    input logic [PITCH_W-1:0] ofs,
    input logic [DRAW_W-1:0]  draw
  );
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.operation    <= op;
    item_ch.pitch_valid  <= pv;
    item_ch.step_pitch   <= pitch;
    item_ch.step_length  <= len;
    item_ch.start_offset <= ofs;
    item_ch.random_draw  <= draw;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic issue_op(input logic [OP_W-1:0] op);
    issue(op, 1'($urandom), rnd_pitch(), LEN_W'($urandom), rnd_pitch(), DRAW_W'($urandom));
  endtask

  task automatic push_step();
    issue(OP_PUSH, ($urandom_range(99) < 75), rnd_pitch(), rnd_len(), rnd_pitch(),
          DRAW_W'($urandom));
  endtask

  task automatic play_session();
    int n_push;
    int n_tick;
    if ($urandom_range(99) < 30) issue_op(OP_CLEAR);
    n_push = $urandom_range(18, 1);
    repeat (n_push) push_step();
    issue_op(OP_START);
    n_tick = $urandom_range(30, 8);
    repeat (n_tick) begin
      case ($urandom_range(19))
        0, 1: issue_op(OP_POP);
        2:    push_step();
        3:    issue_op(OP_CLEAR);
        4:    issue_op(OP_START);
        default: issue_op(OP_TICK);
      endcase
    end
    if ($urandom_range(99) < 80) issue_op(OP_STOP);
  endtask

  task automatic write_order(input order_t ord);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ORDER_ADDR;
    pwdata  <= APB_DATA_W'(ord);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // silent expiries leave no event to wait on, hence the settle time
  task automatic drain_and_settle();
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int goal;
    item_ch.valid        = 1'b0;
    item_ch.operation    = OP_TICK;
    item_ch.pitch_valid  = 1'b0;
    item_ch.step_pitch   = '0;
    item_ch.step_length  = '0;
    item_ch.start_offset = '0;
    item_ch.random_draw  = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle corners: nothing playing, empty table, unused codes
    issue_op(OP_TICK);
    issue_op(OP_STOP);
    issue_op(OP_POP);
    issue_op(OP_SPARE6);
    issue_op(OP_SPARE7);
    issue(OP_START, 1'b0, '0, '0, 16'h7FFF, '0);
    issue_op(OP_TICK);                          // expires on an empty table
    issue(OP_START, 1'b1, 16'hFFFF, 8'hFF, 16'h1234, 8'hFF);  // already playing
    issue(OP_PUSH, 1'b1, 16'h7FFF, 8'd0, '0, '0);  // zero length, saturates high
    issue(OP_PUSH, 1'b0, 16'h8000, 8'd1, '0, '0);  // rest
    issue(OP_PUSH, 1'b1, 16'h8000, 8'd2, '0, '0);
    issue(OP_PUSH, 1'b1, 16'h0100, 8'hFF, '0, '0);
    issue_op(OP_POP);
    repeat (4) issue_op(OP_TICK);
    issue_op(OP_POP);                           // removes the sounding last step
    issue_op(OP_TICK);                          // position now past the table
    issue_op(OP_CLEAR);
    issue_op(OP_TICK);
    issue(OP_PUSH, 1'b1, 16'h8000, 8'd0, '0, '0);
    issue_op(OP_STOP);
    issue(OP_START, 1'b0, '0, '0, 16'h8000, '0);
    issue_op(OP_TICK);                          // saturates low
    issue_op(OP_STOP);
    drain_and_settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_order(PHASE_ORDER[ph]);
      gap_pct   = PHASE_GAP[ph];
      stall_pct = PHASE_STALL[ph];
      goal      = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(99) < 85) begin
          play_session();
        end else begin
          issue(OP_W'($urandom_range(7)), 1'($urandom), rnd_pitch(), LEN_W'($urandom),
                rnd_pitch(), DRAW_W'($urandom));
        end
      end
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("[note_step_sequencer] OK");
    end else begin
      $display("[note_step_sequencer] ERROR");
    end
    $finish;
  end

endmodule
